[sv/lambert_equal_area_projection_defines.svh]
// Assertion macros for the Lambert equal-area projection checker.
`ifndef LAMBERT_EQUAL_AREA_PROJECTION_DEFINES_SVH
`define LAMBERT_EQUAL_AREA_PROJECTION_DEFINES_SVH

// condition that holds on every clock edge out of reset
`define LEA_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lea assertion failed");

// antecedent implies consequent (consequent may carry a fixed delay)
`define LEA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("lea assertion failed");

`endif

[sv/lea_pkg.sv]
// Shared types and constants of the Lambert equal-area projection pipeline.
`timescale 1ns / 1ps
package lea_pkg;

	localparam int ANGLE_BITS_DEF = 32;
	localparam int CORDIC_STEPS   = 30;
	localparam int CW             = 34;
	localparam int DIV_STEPS      = 34;
	localparam int SQRT_STEPS     = 32;
	localparam int PIPE_LAT       = 1 + CORDIC_STEPS + 4 + DIV_STEPS + SQRT_STEPS + 4;

	typedef logic signed [CW-1:0] cq_t;

	localparam cq_t CORDIC_START = 34'sd652032874;
	localparam cq_t Q30_ONE      = 34'sd1073741824;

	localparam cq_t ATAN_TAB [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756, 34'sd42667331,
		34'sd21354465, 34'sd10679838, 34'sd5340245, 34'sd2670163, 34'sd1335087,
		34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
		34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
		34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
	};

	typedef enum logic [2:0] {
		REG_CLAT = 3'd0,
		REG_CLON = 3'd1,
		REG_FE   = 3'd2,
		REG_FN   = 3'd3,
		REG_RAD  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		cq_t                u;
		logic signed [CW:0] v;
		logic [3:0]         e;
		logic               pos;
	} side_t;

endpackage

[sv/lea_cordic.sv]
// Pipelined CORDIC sine and cosine of a binary angle, one stage per iteration.
`timescale 1ns / 1ps
module lea_cordic import lea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_vld,
	input  logic [31:0] angle,
	output logic        out_vld,
	output cq_t         sin_q,
	output cq_t         cos_q
);

	localparam int N = CORDIC_STEPS;

	logic        flip;
	logic [31:0] ang_rot;
	logic        vld_s  [0:N];
	logic        flip_s [0:N];
	cq_t         x_s    [0:N];
	cq_t         y_s    [0:N];
	cq_t         z_s    [0:N];

	assign flip    = ang_rot[31];
	assign ang_rot = angle + 32'h4000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_START;
		y_s[0]    <= '0;
		z_s[0]    <= flip ? cq_t'($signed(angle + 32'h8000_0000)) : cq_t'($signed(angle));
		flip_s[0] <= flip;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_TAB[i];
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_TAB[i];
			end
		end
	end

	assign out_vld = vld_s[N];
	assign sin_q   = flip_s[N] ? -y_s[N] : y_s[N];
	assign cos_q   = flip_s[N] ? -x_s[N] : x_s[N];

endmodule

[sv/lea_div.sv]
// Pipelined restoring divider giving floor(2^63 / dn), one quotient bit per stage.
`timescale 1ns / 1ps
module lea_div import lea_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [31:0]          dn,
	output logic                 out_vld,
	output logic [DIV_STEPS-1:0] quo
);

	localparam int N = DIV_STEPS;

	logic                 vld_s [1:N];
	logic [31:0]          rem_s [1:N];
	logic [31:0]          d_s   [1:N];
	logic [DIV_STEPS-1:0] q_s   [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic                 vp;
		logic [31:0]          rp;
		logic [31:0]          dp;
		logic [DIV_STEPS-1:0] qp;
		logic [32:0]          r2;
		logic                 ge;
		logic [32:0]          rn;

		if (i == 0) begin : g_first
			assign vp = in_vld;
			assign rp = 32'd1 << 29;
			assign dp = dn;
			assign qp = '0;
		end else begin : g_next
			assign vp = vld_s[i];
			assign rp = rem_s[i];
			assign dp = d_s[i];
			assign qp = q_s[i];
		end

		assign r2 = {rp, 1'b0};
		assign ge = r2 >= {1'b0, dp};
		assign rn = ge ? r2 - {1'b0, dp} : r2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= rn[31:0];
			d_s[i+1]   <= dp;
			q_s[i+1]   <= {qp[DIV_STEPS-2:0], ge};
		end
	end

	assign out_vld = vld_s[N];
	assign quo     = q_s[N];

endmodule

[sv/lea_sqrt.sv]
// Pipelined integer square root of quo * 2^28, one root bit per stage.
`timescale 1ns / 1ps
module lea_sqrt import lea_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic [DIV_STEPS-1:0] quo,
	output logic                 out_vld,
	output logic [31:0]          root
);

	localparam int N = SQRT_STEPS;

	logic        vld_s [1:N];
	logic [63:0] val_s [1:N];
	logic [63:0] res_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
		logic        vp;
		logic [63:0] valp;
		logic [63:0] resp;
		logic [63:0] trial;
		logic        ge;

		if (i == 0) begin : g_first
			assign vp   = in_vld;
			assign valp = {2'b00, quo, 28'd0};
			assign resp = '0;
		end else begin : g_next
			assign vp   = vld_s[i];
			assign valp = val_s[i];
			assign resp = res_s[i];
		end

		assign trial = resp + BIT;
		assign ge    = valp >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			val_s[i+1] <= ge ? valp - trial : valp;
			res_s[i+1] <= ge ? (resp >> 1) + BIT : resp >> 1;
		end
	end

	assign out_vld = vld_s[N];
	assign root    = res_s[N][31:0];

endmodule

[sv/lambert_equal_area_projection.sv]
// Top level of the spherical Lambert azimuthal equal-area projection pipeline.
// A point (latitude, longitude) is taken at each clock edge where start is high
// and busy is low; busy stays low, so one point may enter in every cycle.
// The result (easting, northing, no_image) appears on its ports for exactly one
// cycle with done high; results leave in the order in which the points came in.
// Throughput is one point per cycle; a point passes the 31-stage CORDIC (input
// register and 30 iterations), the 34-stage reciprocal divider, the 32-stage
// square root and eight stages of products, normalization, scaling and saturation.
// The receiver cannot stall; results are never held back.
// Configuration (cfg_we, cfg_index, cfg_data) writes one register per edge and
// must only change while no point is in flight.
// Reset clears all valid bits and loads the default projection centre,
// offsets and radius; no result is produced until a point is taken.
`timescale 1ns / 1ps
module lambert_equal_area_projection import lea_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] longitude,
	output logic               done,
	output logic signed [28:0] easting,
	output logic signed [28:0] northing,
	output logic               no_image,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
	localparam int DL = DIV_STEPS + SQRT_STEPS;

	function automatic cq_t mulq(input cq_t a, input cq_t b);
		logic signed [2*CW-1:0] p;
		p = a * b;
		return cq_t'(p >>> 30);
	endfunction

	logic signed [31:0] clat_q;
	logic signed [31:0] clon_q;
	logic signed [27:0] fe_q;
	logic signed [27:0] fn_q;
	logic [22:0]        rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clat_q <= 32'sd656175559;
			clon_q <= 32'sd119304647;
			fe_q   <= 28'sd31200000;
			fn_q   <= -28'sd33600000;
			rad_q  <= 23'd6378140;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLAT: clat_q <= cfg_data;
				REG_CLON: clon_q <= cfg_data;
				REG_FE:   fe_q   <= cfg_data[27:0];
				REG_FN:   fn_q   <= cfg_data[27:0];
				REG_RAD:  rad_q  <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	logic        accept;
	logic [31:0] lat_a;
	logic [31:0] lat0_a;
	logic [31:0] dlon_a;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign lat_a  = latitude & ANGLE_MASK;
	assign lat0_a = clat_q & ANGLE_MASK;
	assign dlon_a = (longitude & ANGLE_MASK) - (clon_q & ANGLE_MASK);

	logic cvld;
	logic cvld_lat0, cvld_lat, cvld_dlon;
	cq_t  s0, c0, s, c, sd, cd;

	lea_cordic u_cor_lat0 (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .angle(lat0_a),
		.out_vld(cvld_lat0), .sin_q(s0), .cos_q(c0)
	);
	lea_cordic u_cor_lat (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .angle(lat_a),
		.out_vld(cvld_lat), .sin_q(s), .cos_q(c)
	);
	lea_cordic u_cor_dlon (
		.clk(clk), .arst_n(arst_n), .in_vld(accept), .angle(dlon_a),
		.out_vld(cvld_dlon), .sin_q(sd), .cos_q(cd)
	);

	assign cvld = cvld_lat0 & cvld_lat & cvld_dlon;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	cq_t  cc_s1, p1_s1, u_s1, t1_s1, t2_s1, cd_s1;
	cq_t  pc_s2, t3_s2, p1_s2, u_s2, t1_s2;
	logic signed [CW+1:0] dq_s3;
	logic signed [CW:0]   v_s3;
	cq_t  u_s3;
	logic [31:0] dn_s4;
	side_t       side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= cvld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		cc_s1 <= mulq(c0, c);
		p1_s1 <= mulq(s0, s);
		u_s1  <= mulq(c, sd);
		t1_s1 <= mulq(c0, s);
		t2_s1 <= mulq(s0, c);
		cd_s1 <= cd;

		pc_s2 <= mulq(cc_s1, cd_s1);
		t3_s2 <= mulq(t2_s1, cd_s1);
		p1_s2 <= p1_s1;
		u_s2  <= u_s1;
		t1_s2 <= t1_s1;

		dq_s3 <= (CW+2)'(Q30_ONE) + (CW+2)'(p1_s2) + (CW+2)'(pc_s2);
		v_s3  <= (CW+1)'(t1_s2) - (CW+1)'(t3_s2);
		u_s3  <= u_s2;
	end

	logic        pos;
	logic [3:0]  e_n;
	logic [31:0] dn_n;

	assign pos = dq_s3 > 0;

	always_comb begin
		logic [63:0] cand;
		e_n  = '0;
		dn_n = 32'h8000_0000;
		for (int k = 15; k >= 0; k--) begin
			cand = {32'd0, dq_s3[31:0]} << (2 * k);
			if (pos && cand >= 64'd1073741824) begin
				e_n  = 4'(k);
				dn_n = cand[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		dn_s4       <= dn_n;
		side_s4.u   <= u_s3;
		side_s4.v   <= v_s3;
		side_s4.e   <= e_n;
		side_s4.pos <= pos;
	end

	logic                 dvld;
	logic [DIV_STEPS-1:0] quo;
	logic                 qvld;
	logic [31:0]          root;

	lea_div u_div (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s4), .dn(dn_s4),
		.out_vld(dvld), .quo(quo)
	);
	lea_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_vld(dvld), .quo(quo),
		.out_vld(qvld), .root(root)
	);

	side_t side_d [1:DL];

	always_ff @(posedge clk) begin
		side_d[1] <= side_s4;
		for (int k = 1; k < DL; k++) begin
			side_d[k+1] <= side_d[k];
		end
	end

	logic vld_s5, vld_s6, vld_s7;
	logic signed [39:0] mu_s5, mv_s5;
	logic [3:0]  e_s5, e_s6;
	logic        pos_s5, pos_s6, pos_s7;
	logic signed [63:0] ru_s6, rv_s6;
	logic signed [63:0] ou_s7, ov_s7;
	logic signed [71:0] pu, pv;
	logic signed [32:0] gs;
	logic signed [23:0] rs;
	logic [4:0]         sh;
	logic signed [63:0] rnd;
	logic signed [63:0] se, sn;

	assign gs  = $signed({1'b0, root});
	assign pu  = 72'(side_d[DL].u) * 72'(gs);
	assign pv  = 72'(side_d[DL].v) * 72'(gs);
	assign rs  = $signed({1'b0, rad_q});
	assign sh  = 5'd26 - {1'b0, e_s6};
	assign rnd = 64'sd1 <<< (sh - 5'd1);
	assign se  = 64'(fe_q) + ou_s7;
	assign sn  = 64'(fn_q) + ov_s7;

	function automatic logic signed [28:0] sat29(input logic signed [63:0] x);
		if (x > 64'sd268435455) begin
			return 29'sd268435455;
		end
		if (x < -64'sd268435456) begin
			return -29'sd268435456;
		end
		return x[28:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s5 <= qvld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			done   <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		mu_s5  <= 40'(pu >>> 30);
		mv_s5  <= 40'(pv >>> 30);
		e_s5   <= side_d[DL].e;
		pos_s5 <= side_d[DL].pos;

		ru_s6  <= 64'(mu_s5) * 64'(rs);
		rv_s6  <= 64'(mv_s5) * 64'(rs);
		e_s6   <= e_s5;
		pos_s6 <= pos_s5;

		ou_s7  <= (ru_s6 + rnd) >>> sh;
		ov_s7  <= (rv_s6 + rnd) >>> sh;
		pos_s7 <= pos_s6;

		easting  <= pos_s7 ? sat29(se) : '0;
		northing <= pos_s7 ? sat29(sn) : '0;
		no_image <= !pos_s7;
	end

endmodule

[sv/lea_checker.sv]
// Port-level checker for the Lambert equal-area projection, bound to the top level.
`timescale 1ns / 1ps
`include "lambert_equal_area_projection_defines.svh"
module lea_checker import lea_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [28:0] easting,
	input logic signed [28:0] northing,
	input logic               no_image
);

	`LEA_ASSERT_ALWAYS(a_never_busy, !busy)
	`LEA_ASSERT_IMPL(a_word_out, start && !busy, ##PIPE_LAT done)
	`LEA_ASSERT_IMPL(a_no_spurious, !(start && !busy), ##PIPE_LAT !done)
	`LEA_ASSERT_IMPL(a_antipode_zero, done && no_image, (easting == 0 && northing == 0))

endmodule

bind lambert_equal_area_projection lea_checker u_lea_checker (.*);
